// ----- rtl/refcounted_slot_allocator_top_defines.svh -----
// assertion macros for the slot allocator checker
// no dependencies; included by rsa_checker.sv
`ifndef REFCOUNTED_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define RSA_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rsa_pkg.sv -----
// shared types, constants and codes of the slot allocator
// no dependencies; used by every file but the defines header
`default_nettype none

package rsa_pkg;

    localparam int SLOTS      = 256;
    localparam int COUNT_BITS = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int NUM_W      = $clog2(SLOTS + 1);

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_GET     = 3'd1,
        CMD_PUT     = 3'd2,
        CMD_FREE    = 3'd3,
        CMD_RETIRE  = 3'd4,
        CMD_LOOKUP  = 3'd5,
        CMD_LEAK    = 3'd6,
        CMD_CLEANUP = 3'd7
    } cmd_e;

    typedef enum logic [3:0] {
        STS_OK         = 4'd0,
        STS_UNINIT     = 4'd1,
        STS_FULL       = 4'd2,
        STS_BAD_HANDLE = 4'd3,
        STS_NOT_IN_USE = 4'd4,
        STS_UNDERFLOW  = 4'd5,
        STS_NOT_FOUND  = 4'd6,
        STS_FREED_REF  = 4'd7,
        STS_SATURATED  = 4'd8
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_EMIT
    } state_e;

    typedef struct packed {
        count_t      refs;
        logic [63:0] origin;
        logic [2:0]  kind;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic single;
        logic scan_start;
        logic scan_step;
        logic scan_finish;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic hit;
        logic scan_done;
        logic out_free;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/rsa_intf.sv -----
// request, response and configuration channels of the slot allocator
// depends on rsa_pkg
`default_nettype none

interface rsa_req_if;
    import rsa_pkg::*;
    logic        valid;
    logic        ready;
    cmd_e        cmd;
    logic [7:0]  slot_index;
    logic [63:0] origin_address;
    logic [2:0]  entry_kind;

    modport source (output valid, cmd, slot_index, origin_address, entry_kind, input ready);
    modport sink (input valid, cmd, slot_index, origin_address, entry_kind, output ready);
endinterface

interface rsa_rsp_if;
    import rsa_pkg::*;
    logic        valid;
    logic        ready;
    status_e     status;
    logic [7:0]  result_slot;
    logic        found;
    logic [15:0] ref_after;
    logic [8:0]  entry_total;

    modport source (output valid, status, result_slot, found, ref_after, entry_total,
                    input ready);
    modport sink (input valid, status, result_slot, found, ref_after, entry_total,
                  output ready);
endinterface

interface rsa_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] slot_count;

    modport source (output valid, slot_count, input ready);
    modport sink (input valid, slot_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/refcounted_slot_allocator_top.sv -----
// top level of the slot allocator: joins rsa_ctrl and rsa_datapath to the channels
// get, put, free, retire: slot read on accept, result set in dispatch, word out in emit
// alloc, lookup, leak count and cleanup scan one slot a cycle over the single read port,
// ending at a hit or past the usable slots; no new accept until the word is emitted
// a word still held by rsp.ready keeps the next one waiting in emit; cfg.ready always high
// async reset clears the slot count and every in-use bit; no clearing pass
`default_nettype none

module refcounted_slot_allocator_top (
    input logic      clk,
    input logic      rst_n,
    rsa_req_if.sink  req,
    rsa_rsp_if.source rsp,
    rsa_cfg_if.sink  cfg
);
    import rsa_pkg::*;

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    assign cfg.ready = 1'b1;

    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    rsa_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .req_cmd            (req.cmd),
        .req_slot_index     (req.slot_index),
        .req_origin_address (req.origin_address),
        .req_entry_kind     (req.entry_kind),
        .cfg_valid          (cfg.valid),
        .cfg_slot_count     (cfg.slot_count),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .rsp_status         (rsp.status),
        .rsp_result_slot    (rsp.result_slot),
        .rsp_found          (rsp.found),
        .rsp_ref_after      (rsp.ref_after),
        .rsp_entry_total    (rsp.entry_total)
    );

endmodule

`default_nettype wire

// ----- rtl/rsa_ctrl.sv -----
// controller state machine of the slot allocator
// depends on rsa_pkg; drives rsa_datapath through ctrl_cmd_t
`default_nettype none

module rsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rsa_pkg::ctrl_sts_t sts,
    output rsa_pkg::ctrl_cmd_t ctl
);
    import rsa_pkg::*;

    state_e state_reg;
    state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = sts.need_scan ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        ctl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ctl.latch = req_valid;
            end
            ST_DISPATCH:
            begin
                ctl.single     = !sts.need_scan;
                ctl.scan_start = sts.need_scan;
            end
            ST_SCAN:
            begin
                ctl.scan_step   = 1'b1;
                ctl.scan_finish = sts.hit || sts.scan_done;
            end
            ST_EMIT:
            begin
                ctl.emit = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/rsa_datapath.sv -----
// slot table, scan counter and result registers of the slot allocator
// depends on rsa_pkg; commanded by rsa_ctrl
`default_nettype none

module rsa_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  rsa_pkg::ctrl_cmd_t ctl,
    output rsa_pkg::ctrl_sts_t sts,
    input  rsa_pkg::cmd_e      req_cmd,
    input  logic [7:0]         req_slot_index,
    input  logic [63:0]        req_origin_address,
    input  logic [2:0]         req_entry_kind,
    input  logic               cfg_valid,
    input  logic [8:0]         cfg_slot_count,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsa_pkg::status_e   rsp_status,
    output logic [7:0]         rsp_result_slot,
    output logic               rsp_found,
    output logic [15:0]        rsp_ref_after,
    output logic [8:0]         rsp_entry_total
);
    import rsa_pkg::*;

    // table storage: in-use bits act as valid bits for the entry memory
    logic [SLOTS-1:0] in_use_reg;
    logic [SLOTS-1:0] in_use_next;
    entry_t           slot_mem [SLOTS];
    entry_t           rd_data_reg;
    slot_t            rd_addr;
    logic             wr_en;
    slot_t            wr_addr;
    entry_t           wr_data;

    logic [8:0]  slot_count_reg;
    cmd_e        cmd_reg;
    logic [7:0]  idx_reg;
    logic [63:0] org_reg;
    logic [2:0]  kind_reg;

    num_t  scan_idx_reg;
    logic  probe_vld_reg;
    slot_t probe_idx_reg;
    num_t  total_reg;

    status_e     res_status_reg;
    logic [7:0]  res_slot_reg;
    logic        res_found_reg;
    logic [15:0] res_ref_reg;
    logic [8:0]  res_total_reg;

    logic        rsp_valid_reg;
    status_e     rsp_status_reg;
    logic [7:0]  rsp_slot_reg;
    logic        rsp_found_reg;
    logic [15:0] rsp_ref_reg;
    logic [8:0]  rsp_total_reg;

    num_t   n_usable;
    slot_t  idx_slot;
    logic   idx_bad;
    logic   idx_used;
    logic   probe_used;
    logic   scan_more;
    logic   hit;
    logic   tally;

    status_e sgl_status;
    count_t  sgl_ref;
    logic    sgl_wr;
    logic    sgl_clr;
    entry_t  sgl_entry;

    status_e     fin_status;
    logic [7:0]  fin_slot;
    logic        fin_found;
    logic [15:0] fin_ref;
    logic [8:0]  fin_total;

    assign n_usable   = (32'(slot_count_reg) > SLOTS) ? NUM_W'(SLOTS) : NUM_W'(slot_count_reg);
    assign idx_slot   = slot_t'(idx_reg);
    assign idx_bad    = 32'(idx_reg) >= 32'(n_usable);
    assign idx_used   = in_use_reg[idx_slot];
    assign probe_used = in_use_reg[probe_idx_reg];
    assign scan_more  = scan_idx_reg < n_usable;

    always_comb
    begin
        hit   = 1'b0;
        tally = 1'b0;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                hit = probe_vld_reg && !probe_used;
            end
            CMD_LOOKUP:
            begin
                hit = probe_vld_reg && probe_used && (rd_data_reg.origin == org_reg);
            end
            CMD_LEAK:
            begin
                tally = probe_vld_reg && probe_used && (rd_data_reg.origin != 64'd0)
                        && (rd_data_reg.refs > count_t'(1));
            end
            CMD_CLEANUP:
            begin
                tally = probe_vld_reg && probe_used;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sts.need_scan = 1'b0;
        case (cmd_reg)
            CMD_ALLOC:   sts.need_scan = n_usable != '0;
            CMD_LOOKUP:  sts.need_scan = org_reg != 64'd0;
            CMD_LEAK:    sts.need_scan = 1'b1;
            CMD_CLEANUP: sts.need_scan = 1'b1;
            default:     sts.need_scan = 1'b0;
        endcase
        sts.hit       = hit;
        sts.scan_done = !probe_vld_reg && !scan_more;
        sts.out_free  = !rsp_valid_reg || rsp_ready;
    end

    // single-slot commands and early-out results
    always_comb
    begin
        sgl_status = STS_OK;
        sgl_ref    = '0;
        sgl_wr     = 1'b0;
        sgl_clr    = 1'b0;
        sgl_entry  = rd_data_reg;
        case (cmd_reg)
            CMD_ALLOC:
            begin
                sgl_status = STS_UNINIT;
            end
            CMD_LOOKUP:
            begin
                sgl_status = STS_NOT_FOUND;
            end
            CMD_GET, CMD_PUT, CMD_FREE, CMD_RETIRE:
            begin
                if (idx_bad)
                begin
                    sgl_status = STS_BAD_HANDLE;
                end
                else if (!idx_used)
                begin
                    sgl_status = STS_NOT_IN_USE;
                end
                else
                begin
                    sgl_wr = 1'b1;
                    if (cmd_reg == CMD_GET)
                    begin
                        if (rd_data_reg.refs == COUNT_MAX)
                        begin
                            sgl_status = STS_SATURATED;
                            sgl_ref    = COUNT_MAX;
                        end
                        else
                        begin
                            sgl_ref = rd_data_reg.refs + count_t'(1);
                        end
                        sgl_entry.refs = sgl_ref;
                    end
                    else if (cmd_reg == CMD_PUT)
                    begin
                        if (rd_data_reg.refs == '0)
                        begin
                            sgl_status = STS_UNDERFLOW;
                        end
                        else
                        begin
                            sgl_ref = rd_data_reg.refs - count_t'(1);
                            sgl_clr = sgl_ref == '0;
                        end
                        sgl_entry.refs = sgl_ref;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_FREE)
                        begin
                            sgl_clr = 1'b1;
                            if (rd_data_reg.refs != '0)
                            begin
                                sgl_status = STS_FREED_REF;
                            end
                        end
                        sgl_entry = '0;
                    end
                end
            end
            default:
            begin
                sgl_status = STS_OK;
            end
        endcase
    end

    always_comb
    begin
        fin_status = STS_OK;
        fin_slot   = '0;
        fin_found  = 1'b0;
        fin_ref    = '0;
        fin_total  = '0;
        if (ctl.single)
        begin
            fin_status = sgl_status;
            fin_ref    = 16'(sgl_ref);
        end
        else if (hit)
        begin
            fin_slot  = 8'(probe_idx_reg);
            fin_found = 1'b1;
            fin_ref   = (cmd_reg == CMD_ALLOC) ? 16'd1 : 16'(rd_data_reg.refs);
        end
        else
        begin
            fin_total = 9'(total_reg);
            case (cmd_reg)
                CMD_ALLOC:  fin_status = STS_FULL;
                CMD_LOOKUP: fin_status = STS_NOT_FOUND;
                default:    fin_status = STS_OK;
            endcase
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_slot;
        wr_data = sgl_entry;
        if (ctl.single && sgl_wr)
        begin
            wr_en = 1'b1;
        end
        else if (ctl.scan_finish && hit && (cmd_reg == CMD_ALLOC))
        begin
            wr_en        = 1'b1;
            wr_addr      = probe_idx_reg;
            wr_data.refs = count_t'(1);
            wr_data.origin = org_reg;
            wr_data.kind = kind_reg;
        end
    end

    always_comb
    begin
        in_use_next = in_use_reg;
        if (cfg_valid)
        begin
            in_use_next = '0;
        end
        else
        begin
            if (ctl.single && sgl_clr)
            begin
                in_use_next[idx_slot] = 1'b0;
            end
            if (ctl.scan_finish && hit && (cmd_reg == CMD_ALLOC))
            begin
                in_use_next[probe_idx_reg] = 1'b1;
            end
            if (ctl.scan_step && tally && (cmd_reg == CMD_CLEANUP))
            begin
                in_use_next[probe_idx_reg] = 1'b0;
            end
        end
    end

    assign rd_addr = ctl.latch ? slot_t'(req_slot_index) : slot_t'(scan_idx_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            slot_count_reg <= '0;
            scan_idx_reg   <= '0;
            probe_vld_reg  <= 1'b0;
            total_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            if (cfg_valid)
            begin
                slot_count_reg <= cfg_slot_count;
            end
            if (ctl.scan_start)
            begin
                scan_idx_reg  <= '0;
                probe_vld_reg <= 1'b0;
                total_reg     <= '0;
            end
            else if (ctl.scan_step)
            begin
                probe_vld_reg <= scan_more;
                if (scan_more)
                begin
                    scan_idx_reg <= scan_idx_reg + num_t'(1);
                end
                if (tally)
                begin
                    total_reg <= total_reg + num_t'(1);
                end
            end
            if (ctl.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg  <= req_cmd;
            idx_reg  <= req_slot_index;
            org_reg  <= req_origin_address;
            kind_reg <= req_entry_kind;
        end
        if (ctl.scan_step)
        begin
            probe_idx_reg <= slot_t'(scan_idx_reg);
        end
        if (ctl.single || ctl.scan_finish)
        begin
            res_status_reg <= fin_status;
            res_slot_reg   <= fin_slot;
            res_found_reg  <= fin_found;
            res_ref_reg    <= fin_ref;
            res_total_reg  <= fin_total;
        end
        if (ctl.emit)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_slot_reg   <= res_slot_reg;
            rsp_found_reg  <= res_found_reg;
            rsp_ref_reg    <= res_ref_reg;
            rsp_total_reg  <= res_total_reg;
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_status      = rsp_status_reg;
    assign rsp_result_slot = rsp_slot_reg;
    assign rsp_found       = rsp_found_reg;
    assign rsp_ref_after   = rsp_ref_reg;
    assign rsp_entry_total = rsp_total_reg;

endmodule

`default_nettype wire

// ----- rtl/rsa_checker.sv -----
// port-level checks on the slot allocator response channel, bound to the top level
// depends on rsa_pkg and refcounted_slot_allocator_top_defines.svh
`default_nettype none
`include "refcounted_slot_allocator_top_defines.svh"

module rsa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input rsa_pkg::status_e rsp_status,
    input logic [7:0]       rsp_result_slot,
    input logic             rsp_found,
    input logic [15:0]      rsp_ref_after,
    input logic [8:0]       rsp_entry_total
);
    import rsa_pkg::*;

    `RSA_ASSERT_NOW(a_found_ok, clk, rst_n, rsp_valid && rsp_found, rsp_status == STS_OK, "slot found with error status")
    `RSA_ASSERT_NOW(a_fail_clean, clk, rst_n, rsp_valid && (rsp_status != STS_OK), !rsp_found && (rsp_result_slot == 8'd0) && (rsp_entry_total == 9'd0), "error word carries slot or total")
    `RSA_ASSERT_NOW(a_total_only, clk, rst_n, rsp_valid && (rsp_entry_total != 9'd0), !rsp_found && (rsp_ref_after == 16'd0), "total word carries slot data")
    `RSA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_slot) && $stable(rsp_found) && $stable(rsp_ref_after) && $stable(rsp_entry_total), "stalled word changed")

endmodule

bind refcounted_slot_allocator_top rsa_checker u_rsa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_result_slot (rsp.result_slot),
    .rsp_found       (rsp.found),
    .rsp_ref_after   (rsp.ref_after),
    .rsp_entry_total (rsp.entry_total)
);

`default_nettype wire

// ----- tb/refcounted_slot_allocator_top_tb.sv -----
// self-checking testbench for the reference-counted slot table allocator
// keeps its own copy of the slot table and checks each response word against it
// depends on rsa_pkg, rsa_intf and refcounted_slot_allocator_top
`default_nettype none

module refcounted_slot_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsa_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        status_e     status;
        logic [7:0]  slot;
        logic        found;
        count_t      refs;
        num_t        total;
    } table_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    rsa_req_if req_ch ();
    rsa_rsp_if rsp_ch ();
    rsa_cfg_if cfg_ch ();

    refcounted_slot_allocator_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // model of the slot table
    logic [8:0]  slot_count_reg;
    bit          tbl_used   [SLOTS];
    count_t      tbl_refs   [SLOTS];
    logic [63:0] tbl_origin [SLOTS];
    logic [2:0]  tbl_kind   [SLOTS];

    table_rsp_t  due_table_rsp [$];
    logic [63:0] origin_pool [8];

    bit          quiet;
    bit          hold_request;
    int unsigned hold_count;
    int unsigned cycle_count;
    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned settings_written;
    int unsigned mismatches;

    always #5 clk = ~clk;

    function automatic int usable_slots();
        return (slot_count_reg > SLOTS) ? SLOTS : int'(slot_count_reg);
    endfunction

    function automatic void clear_table();
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            tbl_used[i]   = 1'b0;
            tbl_refs[i]   = '0;
            tbl_origin[i] = '0;
            tbl_kind[i]   = '0;
        end
    endfunction

    function automatic void init_origin_pool();
        int k;
        origin_pool[0] = '0;
        origin_pool[1] = {64{1'b1}};
        for (k = 2; k < 8; k++)
            origin_pool[k] = {$urandom, $urandom};
    endfunction

    function automatic table_rsp_t apply_table_cmd(input cmd_e cmd, input logic [7:0] idx,
                                                   input logic [63:0] org,
                                                   input logic [2:0] kind);
        table_rsp_t r;
        int         n;
        int         i;
        r = '{status: STS_OK, slot: '0, found: 1'b0, refs: '0, total: '0};
        n = usable_slots();
        case (cmd)
            CMD_ALLOC:
            begin
                if (n == 0)
                    r.status = STS_UNINIT;
                else
                begin
                    r.status = STS_FULL;
                    for (i = 0; i < n; i++)
                    begin
                        if (!tbl_used[i])
                        begin
                            tbl_used[i]   = 1'b1;
                            tbl_refs[i]   = count_t'(1);
                            tbl_origin[i] = org;
                            tbl_kind[i]   = kind;
                            r.status = STS_OK;
                            r.slot   = 8'(i);
                            r.found  = 1'b1;
                            r.refs   = count_t'(1);
                            break;
                        end
                    end
                end
            end
            CMD_GET, CMD_PUT, CMD_FREE, CMD_RETIRE:
            begin
                if (idx >= n)
                    r.status = STS_BAD_HANDLE;
                else if (!tbl_used[idx])
                begin
                    r.status = STS_NOT_IN_USE;
                    r.refs   = tbl_refs[idx];
                end
                else
                begin
                    case (cmd)
                        CMD_GET:
                        begin
                            if (tbl_refs[idx] >= COUNT_MAX)
                            begin
                                tbl_refs[idx] = COUNT_MAX;
                                r.status = STS_SATURATED;
                            end
                            else
                                tbl_refs[idx] = tbl_refs[idx] + 1'b1;
                        end
                        CMD_PUT:
                        begin
                            if (tbl_refs[idx] == 0)
                                r.status = STS_UNDERFLOW;
                            else
                            begin
                                tbl_refs[idx] = tbl_refs[idx] - 1'b1;
                                if (tbl_refs[idx] == 0)
                                    tbl_used[idx] = 1'b0;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (tbl_refs[idx] > 0)
                                r.status = STS_FREED_REF;
                            tbl_used[idx]   = 1'b0;
                            tbl_origin[idx] = '0;
                            tbl_kind[idx]   = '0;
                            tbl_refs[idx]   = '0;
                        end
                        default:
                        begin
                            tbl_origin[idx] = '0;
                            tbl_kind[idx]   = '0;
                            tbl_refs[idx]   = '0;
                        end
                    endcase
                    r.refs = tbl_refs[idx];
                end
            end
            CMD_LOOKUP:
            begin
                r.status = STS_NOT_FOUND;
                if (org != 0)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        if (tbl_used[i] && tbl_origin[i] == org)
                        begin
                            r.status = STS_OK;
                            r.slot   = 8'(i);
                            r.found  = 1'b1;
                            r.refs   = tbl_refs[i];
                            break;
                        end
                    end
                end
            end
            CMD_LEAK:
            begin
                for (i = 0; i < n; i++)
                    if (tbl_used[i] && tbl_origin[i] != 0 && tbl_refs[i] > 1)
                        r.total = r.total + 1'b1;
            end
            default:
            begin
                for (i = 0; i < n; i++)
                begin
                    if (tbl_used[i])
                    begin
                        tbl_used[i]   = 1'b0;
                        tbl_origin[i] = '0;
                        tbl_kind[i]   = '0;
                        tbl_refs[i]   = '0;
                        r.total = r.total + 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pick_busy_slot();
        int n;
        int i;
        int busy [$];
        n = usable_slots();
        for (i = 0; i < n; i++)
            if (tbl_used[i])
                busy.push_back(i);
        if (busy.size() == 0)
            return (n == 0) ? 8'd0 : 8'($urandom_range(0, n - 1));
        return 8'(busy[$urandom_range(0, busy.size() - 1)]);
    endfunction

    // one command word, with an occasional idle burst ahead of it
    task automatic send_table_cmd(input cmd_e cmd, input logic [7:0] idx,
                                  input logic [63:0] org, input logic [2:0] kind);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= cmd;
        req_ch.slot_index     <= idx;
        req_ch.origin_address <= org;
        req_ch.entry_kind     <= kind;
        do @(posedge clk); while (!req_ch.ready);
        due_table_rsp.push_back(apply_table_cmd(cmd, idx, org, kind));
        words_sent++;
    endtask

    task automatic write_slot_count(input logic [8:0] value);
        req_ch.valid <= 1'b0;
        while (due_table_rsp.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.slot_count <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        slot_count_reg = value;
        clear_table();
        settings_written++;
    endtask

    task automatic send_random_cmd();
        int          pick;
        cmd_e        cmd;
        logic [7:0]  idx;
        logic [63:0] org;
        pick = $urandom_range(0, 99);
        if (pick < 22)      cmd = CMD_ALLOC;
        else if (pick < 42) cmd = CMD_GET;
        else if (pick < 62) cmd = CMD_PUT;
        else if (pick < 68) cmd = CMD_FREE;
        else if (pick < 73) cmd = CMD_RETIRE;
        else if (pick < 87) cmd = CMD_LOOKUP;
        else if (pick < 93) cmd = CMD_LEAK;
        else if (pick < 95) cmd = CMD_CLEANUP;
        else                cmd = cmd_e'($urandom_range(0, 7));
        idx = ($urandom_range(0, 99) < 85) ? pick_busy_slot() : 8'($urandom_range(0, 255));
        org = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                          : origin_pool[$urandom_range(0, 7)];
        send_table_cmd(cmd, idx, org, 3'($urandom_range(0, 7)));
    endtask

    task automatic test_uninitialised();
        send_table_cmd(CMD_ALLOC, 8'd0, 64'h1234, 3'd1);
        send_table_cmd(CMD_GET, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_LOOKUP, 8'd0, 64'h1234, 3'd0);
        send_table_cmd(CMD_LEAK, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_CLEANUP, 8'd0, 64'h0, 3'd0);
    endtask

    task automatic test_basic_ops();
        write_slot_count(9'd3);
        send_table_cmd(CMD_ALLOC, 8'd0, {64{1'b1}}, 3'd7);
        send_table_cmd(CMD_ALLOC, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_ALLOC, 8'd0, 64'h5555_5555_5555_5555, 3'd5);
        send_table_cmd(CMD_ALLOC, 8'd0, 64'h77, 3'd1);
        send_table_cmd(CMD_GET, 8'd255, 64'h0, 3'd0);
        send_table_cmd(CMD_GET, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_GET, 8'd1, 64'h0, 3'd0);
        send_table_cmd(CMD_LEAK, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_LOOKUP, 8'd0, {64{1'b1}}, 3'd0);
        send_table_cmd(CMD_LOOKUP, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_PUT, 8'd2, 64'h0, 3'd0);
        send_table_cmd(CMD_GET, 8'd2, 64'h0, 3'd0);
        send_table_cmd(CMD_LOOKUP, 8'd0, 64'h5555_5555_5555_5555, 3'd0);
        send_table_cmd(CMD_RETIRE, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_PUT, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_GET, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_FREE, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_RETIRE, 8'd1, 64'h0, 3'd0);
        send_table_cmd(CMD_FREE, 8'd1, 64'h0, 3'd0);
        send_table_cmd(CMD_ALLOC, 8'd0, 64'hAAAA_AAAA_AAAA_AAAA, 3'd2);
        send_table_cmd(CMD_CLEANUP, 8'd0, 64'h0, 3'd0);
    endtask

    // oversized count acts as the full table
    task automatic test_full_table();
        int i;
        write_slot_count(9'd511);
        for (i = 0; i < SLOTS; i++)
            send_table_cmd(CMD_ALLOC, 8'd0, {56'hC0FFEE_0000_0000, 8'(i)},
                           3'($urandom_range(0, 7)));
        send_table_cmd(CMD_ALLOC, 8'd0, 64'h1, 3'd1);
        send_table_cmd(CMD_LOOKUP, 8'd0, {56'hC0FFEE_0000_0000, 8'd255}, 3'd0);
        send_table_cmd(CMD_GET, 8'd255, 64'h0, 3'd0);
        send_table_cmd(CMD_LEAK, 8'd0, 64'h0, 3'd0);
        send_table_cmd(CMD_CLEANUP, 8'd0, 64'h0, 3'd0);
        write_slot_count(9'd256);
        send_table_cmd(CMD_GET, 8'd255, 64'h0, 3'd0);
    endtask

    task automatic test_input_stall();
        int i;
        write_slot_count(9'd16);
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            send_random_cmd();
    endtask

    task automatic test_random_traffic();
        int unsigned counts [12] = '{3, 1, 8, 2, 16, 0, 5, 4, 64, 300, 7, 2};
        int          phase;
        int          k;
        int          per_phase;
        for (phase = 0; phase < 12; phase++)
        begin
            if (phase == 11)
                quiet = 1'b1;
            write_slot_count(counts[phase][8:0]);
            per_phase = (counts[phase] == 0) ? 30 : 100;
            for (k = 0; k < per_phase; k++)
                send_random_cmd();
        end
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_rsp
        table_rsp_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_table_rsp.size() == 0)
            begin
                $display("%0t: response word with none expected, status %0h", $time,
                         rsp_ch.status);
                mismatches++;
            end
            else
            begin
                want = due_table_rsp.pop_front();
                words_checked++;
                if (rsp_ch.status !== want.status)
                    report_field("status", 64'(want.status), 64'(rsp_ch.status));
                if (rsp_ch.result_slot !== want.slot)
                    report_field("result_slot", 64'(want.slot), 64'(rsp_ch.result_slot));
                if (rsp_ch.found !== want.found)
                    report_field("found", 64'(want.found), 64'(rsp_ch.found));
                if (rsp_ch.ref_after !== want.refs)
                    report_field("ref_after", 64'(want.refs), 64'(rsp_ch.ref_after));
                if (rsp_ch.entry_total !== want.total)
                    report_field("entry_total", 64'(want.total), 64'(rsp_ch.entry_total));
            end
        end
    end

    // response back-pressure, with one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp_ch.ready <= 1'b0;
                for (hold_count = 0; hold_count < 300; hold_count++)
                    @(posedge clk);
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.cmd            <= CMD_ALLOC;
        req_ch.slot_index     <= '0;
        req_ch.origin_address <= '0;
        req_ch.entry_kind     <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.slot_count     <= '0;
        quiet            = 1'b0;
        hold_request     = 1'b0;
        words_sent       = 0;
        words_checked    = 0;
        settings_written = 0;
        mismatches       = 0;
        slot_count_reg   = '0;
        clear_table();
        init_origin_pool();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_uninitialised();
        test_basic_ops();
        test_full_table();
        test_input_stall();
        test_random_traffic();

        req_ch.valid <= 1'b0;
        while (due_table_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered: uninitialised table, every command, full and oversized table,");
        $display("input stall and random traffic: %0d words sent, %0d checked, %0d settings",
                 words_sent, words_checked, settings_written);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
